### hdl/oepf_pkg.sv
// ----------------------------------------------------------------------------
// oepf_pkg
// Shared types, constants and codes of the one-euro pointer filter.
// ----------------------------------------------------------------------------
package oepf_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [19:0] UsPerS     = 20'd1000000;
    localparam logic [18:0] TwoPiQ16   = 19'h6487F;
    localparam logic [16:0] Q16One     = 17'h10000;
    localparam logic [40:0] KStepLimit = 41'h10000000000;
    localparam logic [93:0] KSatNum    = 94'(UsPerS) << 40;
    localparam logic [68:0] KRecipNum  = 69'd1 << 68;
    localparam logic [54:0] KRecip     = 55'((KRecipNum + 69'd15624) / 69'd15625);
    localparam logic signed [31:0] RateMax = 32'sh7FFFFFFF;
    localparam logic signed [31:0] RateMin = 32'sh80000000;
    localparam logic signed [31:0] RateMinSym = 32'sh80000001;

    typedef enum logic [2:0] {
        CFG_BASE_CUTOFF   = 3'd0,
        CFG_SPEED_GAIN    = 3'd1,
        CFG_RATE_CUTOFF   = 3'd2,
        CFG_ALPHA_FLOOR   = 3'd3,
        CFG_ALPHA_CEILING = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] base_cutoff;
        logic [30:0] speed_gain;
        logic [30:0] rate_cutoff;
        logic [16:0] alpha_floor;
        logic [16:0] alpha_ceiling;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] position;
        logic [62:0]        timestamp_us;
        logic               first;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DELTA,
        ST_RAW_START,
        ST_RAW_WAIT,
        ST_K_MUL_LO,
        ST_K_MUL_HI,
        ST_K_SUM,
        ST_K_DIV,
        ST_K_RCP1,
        ST_K_RCP2,
        ST_K_RCP3,
        ST_KK_LO,
        ST_KK_HI,
        ST_KK_SUM,
        ST_A_WAIT,
        ST_A_CLAMP,
        ST_BL_A,
        ST_BL_B,
        ST_BL_SUM,
        ST_CUT_MUL,
        ST_CUT_SUM
    } t_state;

endpackage

### hdl/oepf_in_if.sv
// ----------------------------------------------------------------------------
// oepf_in_if
// Sample channel: pixel position, microsecond timestamp and clear flag.
// ----------------------------------------------------------------------------
interface oepf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] position;
    logic [62:0]        timestamp_us;
    logic               clear_history;

    modport source (output valid, position, timestamp_us, clear_history, input ready);
    modport sink   (input valid, position, timestamp_us, clear_history, output ready);
endinterface

### hdl/oepf_out_if.sv
// ----------------------------------------------------------------------------
// oepf_out_if
// Result channel: smoothed pixel position.
// ----------------------------------------------------------------------------
interface oepf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] smoothed_position;

    modport source (output valid, smoothed_position, input ready);
    modport sink   (input valid, smoothed_position, output ready);
endinterface

### hdl/one_euro_pointer_filter.sv
// ----------------------------------------------------------------------------
// one_euro_pointer_filter
// Q16.16 one-euro smoothing of one pointer axis.
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   position, timestamp_us, clear_history
//   o_out    out  valid/ready   smoothed_position
//   i_cfg_*  in   write enable  register index, data
//
// A seed sample (first or cleared) goes into the result register as it is popped.
// A filter step, from pop to result, first waits on the velocity division,
// then per smoothing factor on the alpha division and the sequencer steps,
// with the cutoff update in between; a saturated time constant skips the
// reciprocal steps. The shared bit-serial divider takes most of the time.
// Reset is synchronous; no clearing pass. A two-entry queue takes samples
// while the back end works; a held result stalls only the finishing step.
// ----------------------------------------------------------------------------
module one_euro_pointer_filter import oepf_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oepf_in_if.sink     i_in,
    oepf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    t_cfg     r_cfg;
    logic     q_push;
    logic     q_pop;
    logic     q_not_full;
    logic     q_valid;
    t_item    f_item;
    t_item    q_item;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_cutoff   <= 31'd65536;
            r_cfg.speed_gain    <= '0;
            r_cfg.rate_cutoff   <= 31'd65536;
            r_cfg.alpha_floor   <= 17'd1;
            r_cfg.alpha_ceiling <= Q16One;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_CUTOFF:   r_cfg.base_cutoff   <= i_cfg_data;
                CFG_SPEED_GAIN:    r_cfg.speed_gain    <= i_cfg_data;
                CFG_RATE_CUTOFF:   r_cfg.rate_cutoff   <= i_cfg_data;
                CFG_ALPHA_FLOOR:   r_cfg.alpha_floor   <= i_cfg_data[16:0];
                CFG_ALPHA_CEILING: r_cfg.alpha_ceiling <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    oepf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_not_full),
        .o_push    (q_push),
        .o_item    (f_item)
    );

    oepf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (f_item),
        .o_not_full (q_not_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_item     (q_item)
    );

    oepf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    oepf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_out     (o_out)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_not_full |-> !i_in.ready)
        else $error("input ready while queue full");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider finished straight after start");
endmodule

### hdl/oepf_front.sv
// ----------------------------------------------------------------------------
// oepf_front
// Accepts samples and marks each one as a history seed or a filter step.
// ----------------------------------------------------------------------------
module oepf_front import oepf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    oepf_in_if.sink i_in,
    input  logic   i_q_ready,
    output logic   o_push,
    output t_item  o_item
);
    logic r_primed;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        o_item.position     = i_in.position;
        o_item.timestamp_us = i_in.timestamp_us;
        o_item.first        = i_in.clear_history || !r_primed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (o_push) begin
            r_primed <= 1'b1;
        end
    end
endmodule

### hdl/oepf_fifo.sv
// ----------------------------------------------------------------------------
// oepf_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module oepf_fifo import oepf_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_cnt;

    assign o_not_full = (r_cnt != CntW'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_item     = r_mem[r_rd];

    function automatic logic [PtrW-1:0] wrap(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### hdl/oepf_div.sv
// ----------------------------------------------------------------------------
// oepf_div
// Restoring divider, one quotient bit per cycle, shared by both variable
// divisions.
// ----------------------------------------------------------------------------
module oepf_div import oepf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_quo;
    logic [63:0] n_shift;
    logic        n_ge;

    assign n_shift = {r_rem[62:0], r_num[63]};
    assign n_ge    = (n_shift >= r_den);

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_shift - r_den : n_shift;
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[62:0], n_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### hdl/oepf_back.sv
// ----------------------------------------------------------------------------
// oepf_back
// Sequencer that runs the velocity estimate, both smoothing factors and
// both blends, and holds the filter history and the result register.
// ----------------------------------------------------------------------------
module oepf_back import oepf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output t_div_req    o_div_req,
    input  t_div_rsp    i_div_rsp,
    oepf_out_if.source  o_out
);
    t_state r_state;
    t_state n_state;

    t_item               r_item;
    logic [62:0]         r_dt;
    logic signed [32:0]  r_delta;
    logic signed [53:0]  r_prod;
    logic                r_neg;
    logic signed [31:0]  r_raw;
    logic                r_phase;
    logic [30:0]         r_cutoff;
    logic [63:0]         r_p0;
    logic [63:0]         r_p1;
    logic signed [63:0]  r_sp0;
    logic signed [63:0]  r_sp1;
    logic [93:0]         r_n;
    logic [108:0]        r_acc;
    logic [40:0]         r_ks;
    logic [16:0]         r_alpha;
    logic signed [31:0]  r_rate;
    logic signed [31:0]  r_last_pos;
    logic signed [31:0]  r_last_rate;
    logic [62:0]         r_last_time;
    logic                r_out_valid;
    logic signed [15:0]  r_out_data;

    logic                out_free;
    logic [63:0]         dt_full;
    logic [52:0]         prod_mag;
    logic [63:0]         ksum;
    logic [42:0]         k_val;
    logic [16:0]         lo;
    logic [16:0]         hi;
    logic signed [63:0]  blend_sum;
    logic signed [31:0]  blend_res;
    logic signed [31:0]  in_q16;
    logic [31:0]         rate_mag;
    logic [46:0]         cut_sum;
    logic [52:0]         raw_q;
    logic [53:0]         k_m;
    logic [26:0]         rcp_a;
    logic [27:0]         rcp_b;
    logic [54:0]         rcp_prod;
    logic [108:0]        rcp_term;
    logic [108:0]        rcp_sum;

    assign out_free          = !r_out_valid || o_out.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.smoothed_position = r_out_data;

    assign dt_full   = {1'b0, i_item.timestamp_us} - {1'b0, r_last_time};
    assign prod_mag  = r_prod[53] ? 53'(-r_prod) : r_prod[52:0];
    assign ksum      = r_p0 + (r_p1 << 32);
    assign k_val     = (ksum[58:16] == '0) ? 43'd1 : ksum[58:16];
    assign lo        = (i_cfg.alpha_floor > Q16One) ? Q16One : i_cfg.alpha_floor;
    assign hi        = (i_cfg.alpha_ceiling > Q16One) ? Q16One : i_cfg.alpha_ceiling;
    assign blend_sum = r_sp0 + r_sp1;
    assign blend_res = blend_sum[47:16];
    assign in_q16    = {r_item.position, 16'b0};
    assign rate_mag  = r_rate[31] ? 32'(-r_rate) : 32'(r_rate);
    assign cut_sum   = 47'((i_cfg.base_cutoff == '0) ? 31'd1 : i_cfg.base_cutoff)
                       + 47'(r_p0[61:16]);
    assign raw_q     = i_div_rsp.quo[52:0];

    assign k_m      = r_n[59:6];
    assign rcp_prod = rcp_a * rcp_b;
    assign rcp_sum  = r_acc + rcp_term;

    always_comb begin
        rcp_a    = k_m[26:0];
        rcp_b    = KRecip[27:0];
        rcp_term = 109'(rcp_prod);
        case (r_state)
            ST_K_RCP1: begin
                rcp_b    = {1'b0, KRecip[54:28]};
                rcp_term = 109'(rcp_prod) << 28;
            end
            ST_K_RCP2: begin
                rcp_a    = k_m[53:27];
                rcp_term = 109'(rcp_prod) << 27;
            end
            ST_K_RCP3: begin
                rcp_a    = k_m[53:27];
                rcp_b    = {1'b0, KRecip[54:28]};
                rcp_term = 109'(rcp_prod) << 55;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_pop           = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.rem   = '0;
        o_div_req.num   = '0;
        o_div_req.den   = '0;
        o_div_req.steps = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_item.first) begin
                        o_pop = out_free;
                    end else begin
                        o_pop   = 1'b1;
                        n_state = ST_DELTA;
                    end
                end
            end
            ST_DELTA:     n_state = ST_RAW_START;
            ST_RAW_START: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {prod_mag, 11'b0};
                o_div_req.den   = 64'(r_dt);
                o_div_req.steps = 7'd53;
                n_state         = ST_RAW_WAIT;
            end
            ST_RAW_WAIT:  if (i_div_rsp.done) n_state = ST_K_MUL_LO;
            ST_K_MUL_LO:  n_state = ST_K_MUL_HI;
            ST_K_MUL_HI:  n_state = ST_K_SUM;
            ST_K_SUM:     n_state = ST_K_DIV;
            ST_K_DIV:     n_state = (r_n >= KSatNum) ? ST_KK_LO : ST_K_RCP1;
            ST_K_RCP1:    n_state = ST_K_RCP2;
            ST_K_RCP2:    n_state = ST_K_RCP3;
            ST_K_RCP3:    n_state = ST_KK_LO;
            ST_KK_LO:     n_state = ST_KK_HI;
            ST_KK_HI:     n_state = ST_KK_SUM;
            ST_KK_SUM: begin
                o_div_req.start = 1'b1;
                o_div_req.rem   = 64'(k_val);
                o_div_req.den   = 64'(k_val) + 64'(Q16One);
                o_div_req.steps = 7'd16;
                n_state         = ST_A_WAIT;
            end
            ST_A_WAIT:    if (i_div_rsp.done) n_state = ST_A_CLAMP;
            ST_A_CLAMP:   n_state = ST_BL_A;
            ST_BL_A:      n_state = ST_BL_B;
            ST_BL_B:      n_state = ST_BL_SUM;
            ST_BL_SUM: begin
                if (!r_phase) begin
                    n_state = ST_CUT_MUL;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CUT_MUL:   n_state = ST_CUT_SUM;
            ST_CUT_SUM:   n_state = ST_K_MUL_LO;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !i_item.first) begin
                    r_item  <= i_item;
                    r_dt    <= (dt_full[63] || dt_full == '0) ? 63'd1 : dt_full[62:0];
                    r_delta <= $signed({i_item.position[15], i_item.position, 16'b0})
                               - $signed({r_last_pos[31], r_last_pos});
                end
            end
            ST_DELTA: r_prod <= 54'(r_delta * $signed({1'b0, UsPerS}));
            ST_RAW_START: r_neg <= r_prod[53];
            ST_RAW_WAIT: begin
                if (i_div_rsp.done) begin
                    if (!r_neg) begin
                        r_raw <= (raw_q > 53'h7FFFFFFF) ? RateMax : $signed(raw_q[31:0]);
                    end else begin
                        r_raw <= (raw_q > 53'h80000000) ? RateMin : -$signed(raw_q[31:0]);
                    end
                    r_cutoff <= (i_cfg.rate_cutoff == '0) ? 31'd1 : i_cfg.rate_cutoff;
                    r_phase  <= 1'b0;
                end
            end
            ST_K_MUL_LO: r_p0 <= 64'(r_cutoff * r_dt[31:0]);
            ST_K_MUL_HI: r_p1 <= 64'(r_cutoff * r_dt[62:32]);
            ST_K_SUM:    r_n  <= 94'(r_p0) + (94'(r_p1) << 32);
            ST_K_DIV: begin
                if (r_n >= KSatNum) begin
                    r_ks <= KStepLimit;
                end else begin
                    r_acc <= rcp_term;
                end
            end
            ST_K_RCP1,
            ST_K_RCP2:   r_acc <= rcp_sum;
            ST_K_RCP3:   r_ks  <= rcp_sum[108:68];
            ST_KK_LO:    r_p0 <= 64'(r_ks[31:0] * TwoPiQ16);
            ST_KK_HI:    r_p1 <= 64'(r_ks[40:32] * TwoPiQ16);
            ST_A_WAIT:   if (i_div_rsp.done) r_alpha <= {1'b0, i_div_rsp.quo[15:0]};
            ST_A_CLAMP: begin
                if (((r_alpha < lo) ? lo : r_alpha) > hi) begin
                    r_alpha <= hi;
                end else if (r_alpha < lo) begin
                    r_alpha <= lo;
                end
            end
            ST_BL_A: begin
                r_sp0 <= 64'($signed({1'b0, r_alpha}) * (r_phase ? in_q16 : r_raw));
            end
            ST_BL_B: begin
                r_sp1 <= 64'($signed({1'b0, Q16One - r_alpha})
                             * (r_phase ? r_last_pos : r_last_rate));
            end
            ST_BL_SUM: begin
                if (!r_phase) begin
                    r_rate <= (blend_res == RateMin) ? RateMinSym : blend_res;
                end
            end
            ST_CUT_MUL:  r_p0 <= 64'(i_cfg.speed_gain * rate_mag[30:0]);
            ST_CUT_SUM: begin
                r_cutoff <= (cut_sum > 47'h7FFFFFFF) ? 31'h7FFFFFFF : cut_sum[30:0];
                r_phase  <= 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos  <= '0;
            r_last_rate <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_IDLE && i_q_valid && i_item.first && out_free) begin
                r_last_pos  <= {i_item.position, 16'b0};
                r_last_rate <= '0;
                r_last_time <= i_item.timestamp_us;
                r_out_valid <= 1'b1;
                r_out_data  <= i_item.position;
            end else if (r_state == ST_BL_SUM && r_phase && out_free) begin
                r_last_pos  <= blend_res;
                r_last_rate <= r_rate;
                r_last_time <= r_item.timestamp_us;
                r_out_valid <= 1'b1;
                r_out_data  <= blend_res[31:16];
            end
        end
    end
endmodule
